// File: rtl/type2_tag_frame_responder_defines.svh
// ----------------------------------------------------------------------------
// type2_tag_frame_responder_defines
// assertion macros shared by the checker
// ----------------------------------------------------------------------------
`ifndef TYPE2_TAG_FRAME_RESPONDER_DEFINES_SVH
`define TYPE2_TAG_FRAME_RESPONDER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define T2TFR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("t2tfr check failed");

// next-cycle implication, disabled during reset
`define T2TFR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("t2tfr check failed");

`endif

// File: rtl/t2tfr_pkg.sv
// ----------------------------------------------------------------------------
// t2tfr_pkg
// types, command codes and crc_a helper for the type 2 tag responder
// ----------------------------------------------------------------------------
package t2tfr_pkg;

    localparam int STORE_BYTES = 1024;
    localparam int STORE_AW    = 10;
    localparam int FRAME_BYTES = 8;
    localparam int FRAME_AW    = 3;
    localparam int FLEN_W      = 4;
    localparam int RSP_BYTES   = 5;

    typedef enum logic [1:0] {
        MODE_RX_BYTE    = 2'd0,
        MODE_RX_SILENCE = 2'd1,
        MODE_HOST_WRITE = 2'd2,
        MODE_HOST_READ  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        TAG_IDLE   = 2'd0,
        TAG_READY  = 2'd1,
        TAG_ACTIVE = 2'd2,
        TAG_HALT   = 2'd3
    } tag_state_t;

    localparam logic CFG_STORAGE_SIZE = 1'b0;
    localparam logic CFG_UID_VALUE    = 1'b1;

    localparam logic [10:0] STORAGE_SIZE_RST = 11'd1024;
    localparam logic [55:0] UID_RST          = 56'h04E3EFA2EF2080;

    localparam logic [15:0] CRC_INIT     = 16'h6363;
    localparam logic [7:0]  CMD_REQA     = 8'h26;
    localparam logic [7:0]  CMD_WUPA     = 8'h52;
    localparam logic [7:0]  CMD_SEL_CL1  = 8'h93;
    localparam logic [7:0]  CMD_SEL_CL2  = 8'h95;
    localparam logic [7:0]  NVB_ANTICOLL = 8'h20;
    localparam logic [7:0]  NVB_SELECT   = 8'h70;
    localparam logic [7:0]  CMD_READ     = 8'h30;
    localparam logic [7:0]  CMD_WRITE    = 8'hA2;
    localparam logic [7:0]  CMD_HLTA     = 8'h50;
    localparam logic [7:0]  HLTA_ARG     = 8'h57;
    localparam logic [7:0]  RSP_ACK      = 8'h0A;
    localparam logic [7:0]  RSP_NAK      = 8'h01;
    localparam logic [7:0]  ATQA_LO      = 8'h44;
    localparam logic [7:0]  ATQA_HI      = 8'h00;
    localparam logic [7:0]  CASCADE_TAG  = 8'h88;
    localparam logic [7:0]  SAK_CL1      = 8'h04;
    localparam logic [7:0]  SAK_CL2      = 8'h00;

    function automatic logic [15:0] crc_a_step(logic [15:0] c, logic [7:0] b);
        logic [7:0] ch;
        ch = b ^ c[7:0];
        ch = ch ^ {ch[3:0], 4'h0};
        return {8'h00, c[15:8]} ^ {ch, 8'h00} ^ {5'b0, ch, 3'b0} ^ {12'h000, ch[7:4]};
    endfunction

    localparam logic [15:0] SAK_CRC_CL1 = crc_a_step(CRC_INIT, SAK_CL1);
    localparam logic [15:0] SAK_CRC_CL2 = crc_a_step(CRC_INIT, SAK_CL2);

endpackage

// File: rtl/type2_tag_frame_responder.sv
// ----------------------------------------------------------------------------
// type2_tag_frame_responder
// frame-level iso 14443-a type 2 tag with host access to tag memory
// ----------------------------------------------------------------------------
//  channel  prefix  direction  payload
//  input    s_      in         mode, data_byte, frame_end, address
//  result   m_      out        out_byte, out_last, out_kind
//  config   cfg_    in         index, data (always ready)
//
//  received bytes without a frame end, silences and host writes keep the block idle
//  a frame end is decoded in the run state, then the emit state sends the response bytes;
//  read answers are bound by the single ram read port
//  write steps through four ram byte writes before its ack
//  synchronous active-low reset; tag memory has no reset
//  a stalled result holds the block in its read, emit or host-read state
module type2_tag_frame_responder
    import t2tfr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [7:0]  s_data_byte,
    input  logic        s_frame_end,
    input  logic [9:0]  s_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_out_last,
    output logic        m_out_kind,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [55:0] cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_RUN, S_READ, S_WRITE, S_EMIT, S_HOST
    } fsm_t;

    fsm_t        state_reg, state_next;
    tag_state_t  tag_reg, tag_next;
    logic [3:0]  sil_reg, sil_next;
    logic [7:0]  frame_reg [FRAME_BYTES];
    logic [7:0]  frame_next [FRAME_BYTES];
    logic [FLEN_W-1:0] flen_reg, flen_next;
    logic [10:0] size_reg, size_next;
    logic [55:0] uid_reg, uid_next;
    logic [7:0]  rsp_reg [RSP_BYTES];
    logic [7:0]  rsp_next [RSP_BYTES];
    logic [2:0]  rlen_reg, rlen_next;
    logic [2:0]  idx_reg, idx_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [10:0] ptr_reg, ptr_next;
    logic [15:0] crc_reg, crc_next;
    logic        dv_reg, dv_next;
    logic        inr_reg, inr_next;
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_byte_reg, m_byte_next;
    logic        m_last_reg, m_last_next;
    logic        m_kind_reg, m_kind_next;

    logic                ram_we, ram_re;
    logic [STORE_AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]          ram_wdata, ram_q;
    logic [10:0]         rd_addr;
    logic [10:0]         pos;
    logic [15:0]         wcrc;
    logic [15:0]         byte_crc;
    logic [7:0]          rd_byte;
    logic                out_free;

    t2tfr_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_mem (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    function automatic logic in_range(logic [10:0] a, logic [10:0] lim);
        return (a < lim) && (a < 11'(STORE_BYTES));
    endfunction

    function automatic logic [7:0] uid_byte(logic [55:0] u, int k);
        return u[8*(6-k) +: 8];
    endfunction

    // crc over the first six frame bytes for write
    always_comb begin
        wcrc = CRC_INIT;
        for (int i = 0; i < 6; i++) begin
            wcrc = crc_a_step(wcrc, frame_reg[i]);
        end
    end

    assign pos      = {1'b0, frame_reg[1], 2'b00};
    assign rd_byte  = inr_reg ? ram_q : 8'h00;
    assign byte_crc = crc_a_step(crc_reg, rd_byte);
    assign out_free = !m_valid_reg || m_ready;
    assign ram_raddr = rd_addr[STORE_AW-1:0];

    always_comb begin
        state_next   = state_reg;
        tag_next     = tag_reg;
        sil_next     = sil_reg;
        frame_next   = frame_reg;
        flen_next    = flen_reg;
        size_next    = size_reg;
        uid_next     = uid_reg;
        rsp_next     = rsp_reg;
        rlen_next    = rlen_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        ptr_next     = ptr_reg;
        crc_next     = crc_reg;
        dv_next      = dv_reg;
        inr_next     = inr_reg;
        m_valid_next = m_valid_reg;
        m_byte_next  = m_byte_reg;
        m_last_next  = m_last_reg;
        m_kind_next  = m_kind_reg;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        rd_addr      = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_STORAGE_SIZE: size_next = cfg_data[10:0];
                CFG_UID_VALUE:    uid_next  = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    case (s_mode)
                        MODE_RX_BYTE: begin
                            if (flen_reg < FLEN_W'(FRAME_BYTES)) begin
                                frame_next[flen_reg[FRAME_AW-1:0]] = s_data_byte;
                                flen_next = flen_reg + 1'b1;
                            end
                            if (s_frame_end) begin
                                state_next = S_RUN;
                            end
                        end
                        MODE_RX_SILENCE: begin
                            for (int i = 0; i < FRAME_BYTES; i++) begin
                                frame_next[i] = 8'h00;
                            end
                            flen_next = '0;
                            if (sil_reg == 4'd7) begin
                                sil_next = '0;
                                tag_next = TAG_IDLE;
                            end else begin
                                sil_next = sil_reg + 1'b1;
                                if (tag_reg == TAG_READY) begin
                                    tag_next = TAG_IDLE;
                                end
                            end
                        end
                        MODE_HOST_WRITE: begin
                            ram_we    = 1'b1;
                            ram_waddr = s_address[STORE_AW-1:0];
                            ram_wdata = s_data_byte;
                        end
                        MODE_HOST_READ: begin
                            ram_re     = 1'b1;
                            rd_addr    = {1'b0, s_address};
                            inr_next   = 1'b1;
                            state_next = S_HOST;
                        end
                        default: ;
                    endcase
                end
            end

            S_RUN: begin
                state_next = S_IDLE;
                idx_next   = '0;
                if (tag_reg == TAG_READY) begin
                    if ((frame_reg[0] == CMD_SEL_CL1) && (frame_reg[1] == NVB_ANTICOLL)) begin
                        rsp_next[0] = CASCADE_TAG;
                        rsp_next[1] = uid_byte(uid_reg, 0);
                        rsp_next[2] = uid_byte(uid_reg, 1);
                        rsp_next[3] = uid_byte(uid_reg, 2);
                        rsp_next[4] = CASCADE_TAG ^ uid_byte(uid_reg, 0)
                                    ^ uid_byte(uid_reg, 1) ^ uid_byte(uid_reg, 2);
                        rlen_next   = 3'd5;
                        state_next  = S_EMIT;
                    end else if ((frame_reg[0] == CMD_SEL_CL2)
                                 && (frame_reg[1] == NVB_ANTICOLL)) begin
                        rsp_next[0] = uid_byte(uid_reg, 3);
                        rsp_next[1] = uid_byte(uid_reg, 4);
                        rsp_next[2] = uid_byte(uid_reg, 5);
                        rsp_next[3] = uid_byte(uid_reg, 6);
                        rsp_next[4] = uid_byte(uid_reg, 3) ^ uid_byte(uid_reg, 4)
                                    ^ uid_byte(uid_reg, 5) ^ uid_byte(uid_reg, 6);
                        rlen_next   = 3'd5;
                        state_next  = S_EMIT;
                    end else if ((frame_reg[0] == CMD_SEL_CL1) && (frame_reg[1] == NVB_SELECT)) begin
                        rsp_next[0] = SAK_CL1;
                        rsp_next[1] = SAK_CRC_CL1[7:0];
                        rsp_next[2] = SAK_CRC_CL1[15:8];
                        rlen_next   = 3'd3;
                        state_next  = S_EMIT;
                    end else if ((frame_reg[0] == CMD_SEL_CL2) && (frame_reg[1] == NVB_SELECT)) begin
                        rsp_next[0] = SAK_CL2;
                        rsp_next[1] = SAK_CRC_CL2[7:0];
                        rsp_next[2] = SAK_CRC_CL2[15:8];
                        rlen_next   = 3'd3;
                        tag_next    = TAG_ACTIVE;
                        state_next  = S_EMIT;
                    end else begin
                        tag_next = TAG_IDLE;
                    end
                end else if (tag_reg == TAG_ACTIVE) begin
                    if (frame_reg[0] == CMD_READ) begin
                        ram_re     = 1'b1;
                        rd_addr    = pos;
                        inr_next   = in_range(pos, size_reg);
                        ptr_next   = pos + 11'd1;
                        cnt_next   = '0;
                        crc_next   = CRC_INIT;
                        state_next = S_READ;
                    end else if (frame_reg[0] == CMD_WRITE) begin
                        if ((frame_reg[6] == wcrc[7:0]) && (frame_reg[7] == wcrc[15:8])) begin
                            ptr_next   = pos;
                            cnt_next   = '0;
                            state_next = S_WRITE;
                        end else begin
                            rsp_next[0] = RSP_NAK;
                            rlen_next   = 3'd1;
                            state_next  = S_EMIT;
                        end
                    end else if ((frame_reg[0] == CMD_HLTA) && (frame_reg[2] == HLTA_ARG)) begin
                        tag_next = TAG_HALT;
                    end else if (flen_reg != '0) begin
                        tag_next = TAG_IDLE;
                    end
                end else if ((flen_reg == FLEN_W'(1))
                             && ((frame_reg[0] == CMD_REQA) || (frame_reg[0] == CMD_WUPA))) begin
                    rsp_next[0] = ATQA_LO;
                    rsp_next[1] = ATQA_HI;
                    rlen_next   = 3'd2;
                    tag_next    = TAG_READY;
                    state_next  = S_EMIT;
                end
                // write still needs the data bytes, it clears the frame itself
                if (state_next != S_WRITE) begin
                    for (int i = 0; i < FRAME_BYTES; i++) begin
                        frame_next[i] = 8'h00;
                    end
                    flen_next = '0;
                end
            end

            S_READ: begin
                if (dv_reg && out_free) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = rd_byte;
                    m_last_next  = 1'b0;
                    m_kind_next  = 1'b0;
                    crc_next     = byte_crc;
                    cnt_next     = cnt_reg + 1'b1;
                    if (cnt_reg == 4'd15) begin
                        rsp_next[0] = byte_crc[7:0];
                        rsp_next[1] = byte_crc[15:8];
                        rlen_next   = 3'd2;
                        idx_next    = '0;
                        state_next  = S_EMIT;
                    end else begin
                        // fetch the next byte while this one goes out
                        ram_re   = 1'b1;
                        rd_addr  = ptr_reg;
                        inr_next = in_range(ptr_reg, size_reg);
                        ptr_next = ptr_reg + 11'd1;
                    end
                end
            end

            S_WRITE: begin
                ram_we    = in_range(ptr_reg, size_reg);
                ram_waddr = ptr_reg[STORE_AW-1:0];
                ram_wdata = frame_reg[FRAME_AW'(cnt_reg[1:0]) + FRAME_AW'(2)];
                ptr_next  = ptr_reg + 11'd1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg[1:0] == 2'd3) begin
                    rsp_next[0] = RSP_ACK;
                    rlen_next   = 3'd1;
                    idx_next    = '0;
                    state_next  = S_EMIT;
                    for (int i = 0; i < FRAME_BYTES; i++) begin
                        frame_next[i] = 8'h00;
                    end
                    flen_next = '0;
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = rsp_reg[idx_reg];
                    m_last_next  = (idx_reg == rlen_reg - 3'd1);
                    m_kind_next  = 1'b0;
                    idx_next     = idx_reg + 1'b1;
                    if (idx_reg == rlen_reg - 3'd1) begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_HOST: begin
                if (dv_reg && out_free) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = ram_q;
                    m_last_next  = 1'b1;
                    m_kind_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase

        // ram output is fresh after a read, spent once it has been sent
        if (ram_re) begin
            dv_next = 1'b1;
        end else if (dv_reg && out_free && ((state_reg == S_READ) || (state_reg == S_HOST))) begin
            dv_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            tag_reg     <= TAG_IDLE;
            sil_reg     <= '0;
            flen_reg    <= '0;
            size_reg    <= STORAGE_SIZE_RST;
            uid_reg     <= UID_RST;
            dv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < FRAME_BYTES; i++) begin
                frame_reg[i] <= 8'h00;
            end
        end else begin
            state_reg   <= state_next;
            tag_reg     <= tag_next;
            sil_reg     <= sil_next;
            flen_reg    <= flen_next;
            size_reg    <= size_next;
            uid_reg     <= uid_next;
            dv_reg      <= dv_next;
            m_valid_reg <= m_valid_next;
            frame_reg   <= frame_next;
            rsp_reg     <= rsp_next;
            rlen_reg    <= rlen_next;
            idx_reg     <= idx_next;
            cnt_reg     <= cnt_next;
            ptr_reg     <= ptr_next;
            crc_reg     <= crc_next;
            inr_reg     <= inr_next;
            m_byte_reg  <= m_byte_next;
            m_last_reg  <= m_last_next;
            m_kind_reg  <= m_kind_next;
        end
    end

    assign s_ready    = (state_reg == S_IDLE);
    assign cfg_ready  = 1'b1;
    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_byte_reg;
    assign m_out_last = m_last_reg;
    assign m_out_kind = m_kind_reg;

endmodule

// File: rtl/t2tfr_ram.sv
// ----------------------------------------------------------------------------
// t2tfr_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module t2tfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/t2tfr_checker.sv
// ----------------------------------------------------------------------------
// t2tfr_checker
// port-level checks for the type 2 tag responder
// ----------------------------------------------------------------------------
`include "type2_tag_frame_responder_defines.svh"

module t2tfr_checker
    import t2tfr_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [1:0]  s_mode,
    input logic        s_frame_end,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_out_byte,
    input logic        m_out_last,
    input logic        m_out_kind
);

    logic m_stall;
    logic acc_host_read;
    logic acc_rx_mid;

    assign m_stall       = m_valid && !m_ready;
    assign acc_host_read = s_valid && s_ready && (s_mode == MODE_HOST_READ);
    assign acc_rx_mid    = s_valid && s_ready && (s_mode == MODE_RX_BYTE) && !s_frame_end;

    // a stalled result transaction keeps its byte
    `T2TFR_ASSERT_NEXT(a_hold, aclk, aresetn, m_stall, m_valid && $stable(m_out_byte))

    // a host readback is a single-byte response
    `T2TFR_ASSERT_NOW(a_host_last, aclk, aresetn, m_valid && m_out_kind, m_out_last)

    // a host read keeps the input side busy while it fetches
    `T2TFR_ASSERT_NEXT(a_host_busy, aclk, aresetn, acc_host_read, !s_ready)

    // a frame byte that is not the last one is absorbed at once
    `T2TFR_ASSERT_NEXT(a_byte_quick, aclk, aresetn, acc_rx_mid, s_ready)

endmodule

bind type2_tag_frame_responder t2tfr_checker u_t2tfr_checker (.*);

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the type 2 tag frame responder: a queue-fed driver
// sends received bytes, silences and host accesses, a predictor of the tag
// state machine builds the expected response bytes, and a monitor compares
// every result transaction against them under random stalls on both sides
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import t2tfr_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 40;

    typedef struct {
        mode_t      mode;
        logic [7:0] data;
        logic       fend;
        logic [9:0] addr;
    } rx_item_t;

    typedef struct {
        logic [7:0] b;
        logic       last;
        logic       kind;
    } tag_reply_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_mode = '0;
    logic [7:0]  s_data_byte = '0;
    logic        s_frame_end = 1'b0;
    logic [9:0]  s_address = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_out_last;
    logic        m_out_kind;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [55:0] cfg_data = '0;

    type2_tag_frame_responder i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_data_byte (s_data_byte),
        .s_frame_end (s_frame_end),
        .s_address   (s_address),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_out_last  (m_out_last),
        .m_out_kind  (m_out_kind),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #10 aclk = ~aclk;

    // tag model state
    logic [7:0]  rx_frame [FRAME_BYTES];
    int          rx_len;
    tag_state_t  tag_st;
    int          silences;
    logic [7:0]  tag_mem [STORE_BYTES];
    logic [10:0] mem_in_use;
    logic [55:0] tag_uid;
    logic [7:0]  reply_buf [18];
    logic [7:0]  crc_work [18];

    rx_item_t    pending_items [$];
    tag_reply_t  expected_replies [$];
    logic [7:0]  frame_bytes [$];
    rx_item_t    cur_item;

    int  failures = 0;
    int  items_sent = 0;
    int  replies_seen = 0;
    int  cycles = 0;
    int  send_gap = 0;
    int  recv_stall = 0;
    int  random_items = 0;
    bit  quiet = 1'b0;

    function automatic logic [15:0] crc_of_work(int n);
        logic [15:0] c;
        logic [7:0]  ch;
        c = CRC_INIT;
        for (int i = 0; i < n; i++) begin
            ch = crc_work[i] ^ c[7:0];
            ch = ch ^ (ch << 4);
            c = (c >> 8) ^ ({8'h00, ch} << 8) ^ ({8'h00, ch} << 3) ^ ({8'h00, ch} >> 4);
        end
        return c;
    endfunction

    function automatic logic [7:0] uid_part(int k);
        return tag_uid[8*(6-k) +: 8];
    endfunction

    function automatic void queue_reply(int n);
        tag_reply_t r;
        for (int i = 0; i < n; i++) begin
            r.b = reply_buf[i];
            r.last = (i == n - 1);
            r.kind = 1'b0;
            expected_replies.push_back(r);
        end
    endfunction

    function automatic void clear_rx_frame();
        for (int i = 0; i < FRAME_BYTES; i++)
            rx_frame[i] = 8'h00;
        rx_len = 0;
    endfunction

    function automatic void answer_frame();
        int pos;
        int lim;
        logic [15:0] c;
        lim = (mem_in_use < STORE_BYTES) ? int'(mem_in_use) : STORE_BYTES;
        pos = int'(rx_frame[1]) * 4;
        if (tag_st == TAG_READY) begin
            if (rx_frame[0] == CMD_SEL_CL1 && rx_frame[1] == NVB_ANTICOLL) begin
                reply_buf[0] = CASCADE_TAG;
                for (int i = 1; i < 4; i++)
                    reply_buf[i] = uid_part(i - 1);
                reply_buf[4] = reply_buf[0] ^ reply_buf[1] ^ reply_buf[2] ^ reply_buf[3];
                queue_reply(5);
            end else if (rx_frame[0] == CMD_SEL_CL2 && rx_frame[1] == NVB_ANTICOLL) begin
                for (int i = 0; i < 4; i++)
                    reply_buf[i] = uid_part(i + 3);
                reply_buf[4] = reply_buf[0] ^ reply_buf[1] ^ reply_buf[2] ^ reply_buf[3];
                queue_reply(5);
            end else if ((rx_frame[0] == CMD_SEL_CL1 || rx_frame[0] == CMD_SEL_CL2)
                         && rx_frame[1] == NVB_SELECT) begin
                reply_buf[0] = (rx_frame[0] == CMD_SEL_CL1) ? SAK_CL1 : SAK_CL2;
                crc_work[0] = reply_buf[0];
                c = crc_of_work(1);
                reply_buf[1] = c[7:0];
                reply_buf[2] = c[15:8];
                if (rx_frame[0] == CMD_SEL_CL2)
                    tag_st = TAG_ACTIVE;
                queue_reply(3);
            end else begin
                tag_st = TAG_IDLE;
            end
        end else if (tag_st == TAG_ACTIVE) begin
            if (rx_frame[0] == CMD_READ) begin
                for (int i = 0; i < 16; i++) begin
                    reply_buf[i] = (pos + i < lim) ? tag_mem[pos + i] : 8'h00;
                    crc_work[i] = reply_buf[i];
                end
                c = crc_of_work(16);
                reply_buf[16] = c[7:0];
                reply_buf[17] = c[15:8];
                queue_reply(18);
            end else if (rx_frame[0] == CMD_WRITE) begin
                for (int i = 0; i < 6; i++)
                    crc_work[i] = rx_frame[i];
                c = crc_of_work(6);
                if (rx_frame[6] == c[7:0] && rx_frame[7] == c[15:8]) begin
                    for (int i = 0; i < 4; i++)
                        if (pos + i < lim)
                            tag_mem[pos + i] = rx_frame[2 + i];
                    reply_buf[0] = RSP_ACK;
                end else begin
                    reply_buf[0] = RSP_NAK;
                end
                queue_reply(1);
            end else if (rx_frame[0] == CMD_HLTA && rx_frame[2] == HLTA_ARG) begin
                tag_st = TAG_HALT;
            end else if (rx_len != 0) begin
                tag_st = TAG_IDLE;
            end
        end else if (rx_len == 1 && (rx_frame[0] == CMD_REQA || rx_frame[0] == CMD_WUPA)) begin
            reply_buf[0] = ATQA_LO;
            reply_buf[1] = ATQA_HI;
            tag_st = TAG_READY;
            queue_reply(2);
        end
    endfunction

    function automatic void tag_predict(rx_item_t it);
        tag_reply_t r;
        case (it.mode)
            MODE_RX_BYTE: begin
                if (rx_len < FRAME_BYTES) begin
                    rx_frame[rx_len] = it.data;
                    rx_len++;
                end
                if (it.fend) begin
                    answer_frame();
                    clear_rx_frame();
                end
            end
            MODE_RX_SILENCE: begin
                clear_rx_frame();
                answer_frame();
                clear_rx_frame();
                silences++;
                if (silences >= 8) begin
                    silences = 0;
                    tag_st = TAG_IDLE;
                end
            end
            MODE_HOST_WRITE: tag_mem[it.addr] = it.data;
            default: begin
                r.b = tag_mem[it.addr];
                r.last = 1'b1;
                r.kind = 1'b1;
                expected_replies.push_back(r);
            end
        endcase
    endfunction

    // driver: one transaction per accepted item, gaps in random bursts
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                tag_predict(cur_item);
                items_sent++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(0, 3);
                    s_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    cur_item = pending_items.pop_front();
                    s_mode <= cur_item.mode;
                    s_data_byte <= cur_item.data;
                    s_frame_end <= cur_item.fend;
                    s_address <= cur_item.addr;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and result-side stalls
    always @(posedge aclk) begin
        tag_reply_t e;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            replies_seen++;
            if (expected_replies.size() == 0) begin
                $error("unexpected result transaction, out_byte %h", m_out_byte);
                failures++;
            end else begin
                e = expected_replies.pop_front();
                if (m_out_byte !== e.b) begin
                    $error("out_byte expected %h actual %h", e.b, m_out_byte);
                    failures++;
                end
                if (m_out_last !== e.last) begin
                    $error("out_last expected %b actual %b", e.last, m_out_last);
                    failures++;
                end
                if (m_out_kind !== e.kind) begin
                    $error("out_kind expected %b actual %b", e.kind, m_out_kind);
                    failures++;
                end
            end
        end
        if (aresetn) begin
            if (recv_stall == 0 && !quiet && $urandom_range(0, 5) == 0)
                recv_stall = $urandom_range(1, 4);
            if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic void push_item(mode_t m, logic [7:0] d, logic fe, logic [9:0] a);
        rx_item_t it;
        it.mode = m;
        it.data = d;
        it.fend = fe;
        it.addr = a;
        pending_items.push_back(it);
        random_items++;
    endfunction

    // reads only go to the preloaded bytes: 0..15 and the last four
    function automatic logic [9:0] loaded_addr();
        if ($urandom_range(0, 4) == 0)
            return 10'(STORE_BYTES - 4 + $urandom_range(0, 3));
        return 10'($urandom_range(0, 15));
    endfunction

    // block 0 lies in the preloaded bytes, block 0xff starts on the last four
    function automatic logic [7:0] read_block();
        return ($urandom_range(0, 3) == 0) ? 8'hFF : 8'h00;
    endfunction

    // random byte that never opens a read command
    function automatic logic [7:0] rand_cmd();
        logic [7:0] b;
        b = 8'($urandom);
        if (b == CMD_READ)
            b = b ^ 8'h01;
        return b;
    endfunction

    function automatic void send_frame();
        int n;
        n = frame_bytes.size();
        for (int i = 0; i < n; i++)
            push_item(MODE_RX_BYTE, frame_bytes[i], i == n - 1, 10'($urandom));
        frame_bytes.delete();
    endfunction

    function automatic void add_crc();
        logic [15:0] c;
        for (int i = 0; i < frame_bytes.size(); i++)
            crc_work[i] = frame_bytes[i];
        c = crc_of_work(frame_bytes.size());
        frame_bytes.push_back(c[7:0]);
        frame_bytes.push_back(c[15:8]);
    endfunction

    function automatic void read_frame(logic [7:0] blk);
        frame_bytes = '{CMD_READ, blk};
        add_crc();
        send_frame();
    endfunction

    function automatic void write_frame(logic [7:0] blk, bit good);
        frame_bytes = '{CMD_WRITE, blk, 8'($urandom), 8'($urandom),
                        8'($urandom), 8'($urandom)};
        add_crc();
        if (!good)
            frame_bytes[6] = frame_bytes[6] ^ 8'(1 << $urandom_range(0, 7));
        send_frame();
    endfunction

    // wake the tag and walk both cascade levels into active
    function automatic void wake_and_select();
        frame_bytes = '{($urandom_range(0, 1) != 0) ? CMD_REQA : CMD_WUPA};
        send_frame();
        frame_bytes = '{CMD_SEL_CL1, NVB_ANTICOLL};
        send_frame();
        frame_bytes = '{CMD_SEL_CL1, NVB_SELECT};
        send_frame();
        frame_bytes = '{CMD_SEL_CL2, NVB_ANTICOLL};
        send_frame();
        frame_bytes = '{CMD_SEL_CL2, NVB_SELECT};
        send_frame();
    endfunction

    function automatic void random_session();
        int steps;
        frame_bytes = '{8'h00};
        send_frame();
        if ($urandom_range(0, 9) == 0) begin
            // broken: random frame where a command belongs
            steps = $urandom_range(1, 9);
            for (int i = 0; i < steps; i++)
                frame_bytes.push_back(rand_cmd());
            send_frame();
        end
        wake_and_select();
        steps = $urandom_range(1, 5);
        for (int i = 0; i < steps; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: read_frame(read_block());
                3, 4:    write_frame(8'($urandom), $urandom_range(0, 4) != 0);
                5:       push_item(MODE_HOST_WRITE, 8'($urandom), 1'($urandom), 10'($urandom));
                6:       push_item(MODE_HOST_READ, 8'($urandom), 1'($urandom), loaded_addr());
                7:       push_item(MODE_RX_SILENCE, 8'($urandom), 1'($urandom), 10'($urandom));
                default: begin
                    frame_bytes = '{rand_cmd(), 8'($urandom), 8'($urandom)};
                    send_frame();
                end
            endcase
        end
        if ($urandom_range(0, 1) != 0) begin
            frame_bytes = '{CMD_HLTA, 8'h00, HLTA_ARG, 8'($urandom)};
            send_frame();
        end
        if ($urandom_range(0, 3) == 0) begin
            for (int i = $urandom_range(1, 6); i > 0; i--)
                push_item(mode_t'($urandom_range(0, 3)), rand_cmd(), 1'($urandom),
                          loaded_addr());
        end
    endfunction

    task automatic wait_idle();
        while (pending_items.size() != 0 || s_valid || expected_replies.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [55:0] val);
        wait_idle();
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_STORAGE_SIZE)
            mem_in_use = val[10:0];
        else
            tag_uid = val;
    endtask

    task automatic random_phase(int n);
        random_items = 0;
        while (random_items < n)
            random_session();
    endtask

    initial begin
        clear_rx_frame();
        tag_st = TAG_IDLE;
        silences = 0;
        mem_in_use = STORAGE_SIZE_RST;
        tag_uid = UID_RST;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_reg(CFG_STORAGE_SIZE, 56'd1024);
        write_reg(CFG_UID_VALUE, UID_RST);
        // load the bytes that every read is steered to
        for (int a = 0; a < 16; a++)
            push_item(MODE_HOST_WRITE, 8'($urandom), 1'b0, 10'(a));
        for (int a = STORE_BYTES - 4; a < STORE_BYTES; a++)
            push_item(MODE_HOST_WRITE, 8'($urandom), 1'b0, 10'(a));

        // directed: full session, special cases, field extremes
        push_item(MODE_RX_SILENCE, 8'hFF, 1'b1, 10'h3FF);
        frame_bytes = '{CMD_REQA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                        8'hFF};
        send_frame();                          // overflow, no answer in idle
        frame_bytes = '{CMD_REQA};
        send_frame();
        push_item(MODE_RX_SILENCE, 8'h00, 1'b0, 10'h000);     // ready back to idle
        frame_bytes = '{CMD_WUPA};
        send_frame();
        frame_bytes = '{CMD_SEL_CL1, NVB_ANTICOLL, 8'h55};     // extra byte ignored
        send_frame();
        frame_bytes = '{CMD_SEL_CL2, NVB_SELECT};
        send_frame();
        push_item(MODE_RX_SILENCE, 8'h00, 1'b0, 10'h000);     // empty frame in active
        read_frame(8'h00);
        write_frame(8'h01, 1'b1);
        read_frame(8'h00);
        write_frame(8'h02, 1'b0);
        read_frame(8'hFF);                     // runs past the end of storage
        write_frame(8'hFF, 1'b1);
        push_item(MODE_HOST_READ, 8'h00, 1'b1, 10'h3FF);
        push_item(MODE_HOST_WRITE, 8'hFF, 1'b1, 10'h000);
        push_item(MODE_HOST_READ, 8'hFF, 1'b0, 10'h000);
        frame_bytes = '{CMD_HLTA, 8'h00, HLTA_ARG, 8'h00};
        send_frame();
        frame_bytes = '{CMD_REQA};
        send_frame();                          // halted tag wakes
        frame_bytes = '{8'h12, 8'h34};
        send_frame();                          // unknown in ready
        wake_and_select();
        frame_bytes = '{8'hC3};
        send_frame();                          // unknown in active
        for (int i = 0; i < 8; i++)
            push_item(MODE_RX_SILENCE, 8'($urandom), 1'($urandom), 10'($urandom));

        write_reg(CFG_STORAGE_SIZE, 56'd0);
        write_reg(CFG_UID_VALUE, 56'd0);
        random_phase(20);
        write_reg(CFG_STORAGE_SIZE, 56'h7FF);
        write_reg(CFG_UID_VALUE, {56{1'b1}});
        random_phase(20);
        write_reg(CFG_STORAGE_SIZE, 56'($urandom_range(16, 1023)));
        write_reg(CFG_UID_VALUE, {24'($urandom), 32'($urandom)});
        quiet = 1'b1;
        random_phase(20);

        wait_idle();
        $display("covered %0d input transactions and %0d result transactions across",
                 items_sent, replies_seen);
        $display("wake, cascade select, read, write, halt, silence and host access paths");
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/t2tfr_pkg.sv
rtl/t2tfr_ram.sv
rtl/type2_tag_frame_responder.sv
rtl/t2tfr_checker.sv
test/tb_top.sv
